FILE: hdl/stereo_meter_ballistics_top_macros.svh
// Assertion macros shared by the stereo meter ballistics RTL.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef STEREO_METER_BALLISTICS_TOP_MACROS_SVH
`define STEREO_METER_BALLISTICS_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define SMB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smb assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define SMB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smb assertion failed");
`else
`define SMB_ASSERT_IMP(lbl, ante, cons)
`define SMB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/smb_pkg.sv
// Package for the stereo meter ballistics block: default widths, reset values,
// register indexes and the sequencer state type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package smb_pkg;

    localparam int LEVEL_BITS_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int HOLD_BITS_DEF   = 8;

    // Configuration register defaults.
    localparam logic [15:0]        LEVEL_COEF_RST = 16'd16384;
    localparam logic [15:0]        CORR_COEF_RST  = 16'd9830;
    localparam logic [7:0]         HOLD_TICKS_RST = 8'd40;
    localparam logic [12:0]        FALL_STEP_RST  = 13'd230;
    localparam logic signed [15:0] FLOOR_DB_RST   = -16'sd15360;

    // Levels and peaks start at minus 60 dB.
    localparam int RESET_DB    = -15360;
    localparam int ONE_DB      = 256;
    localparam int CORR_MAX    = 32767;
    localparam int COEF_SHIFT  = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LEVEL_COEF = 3'd0,
        CFG_CORR_COEF  = 3'd1,
        CFG_HOLD_TICKS = 3'd2,
        CFG_FALL_STEP  = 3'd3,
        CFG_FLOOR_DB   = 3'd4
    } smb_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MID,
        ST_SIDE,
        ST_LR,
        ST_INST,
        ST_CMUL,
        ST_CUPD,
        ST_EMIT
    } smb_state_t;

endpackage

`default_nettype wire

FILE: hdl/stereo_meter_ballistics_top.sv
// Top level of the stereo meter ballistics block: level smoothing, peak hold
// and phase correlation around one shared multiplier. Depends on smb_pkg and
// stereo_meter_ballistics_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_meter_ballistics_top_macros.svh"

// Each accepted input word (mid and side levels in Q7.8 dB, one left and one
// right sample in Q1.15) yields exactly one output word carrying the smoothed
// levels, the held and falling peaks, the smoothed L*R correlation and the
// two silence flags. All four products (two level updates, L*R and the
// correlation update) go through a single signed multiplier, one product per
// cycle, under a small sequencer, so a word is accepted, worked through the
// states ST_MID to ST_EMIT and handed to the output register; in_ready returns on
// the cycle after, so no new word is taken before the last one has been handed on.
// The output register holds the finished word, so a slow consumer only stalls
// the block when a second word is ready to leave before the first has gone.
// Configuration writes (cfg_valid with cfg_index and cfg_data) are always
// taken at once; they should only be issued while no word is in flight.
// Unknown register indexes are ignored.
module stereo_meter_ballistics_top #(
    parameter int LEVEL_BITS  = smb_pkg::LEVEL_BITS_DEF,
    parameter int SAMPLE_BITS = smb_pkg::SAMPLE_BITS_DEF,
    parameter int HOLD_BITS   = smb_pkg::HOLD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration write channel.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [smb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [smb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // Input channel.
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [LEVEL_BITS-1:0]        mid_db_in,
    input  wire logic signed [LEVEL_BITS-1:0]        side_db_in,
    input  wire logic signed [SAMPLE_BITS-1:0]       left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]       right_sample,
    // Output channel.
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [LEVEL_BITS-1:0]             mid_level,
    output logic signed [LEVEL_BITS-1:0]             side_level,
    output logic signed [LEVEL_BITS-1:0]             mid_pk_level,
    output logic signed [LEVEL_BITS-1:0]             side_pk_level,
    output logic signed [15:0]                       correlation,
    output logic                                     mid_silent,
    output logic                                     side_silent
);

    import smb_pkg::*;

    // Internal level width: wide enough for the minus 60 dB reset value even
    // when the level ports are narrower than 16 bits.
    localparam int SW = (LEVEL_BITS > 16) ? LEVEL_BITS : 16;
    // Multiplier operand widths: a level or correlation difference or a sample on
    // side A, a coefficient or a sample on side B.
    localparam int AW = (SW + 1 > SAMPLE_BITS) ? SW + 1 : SAMPLE_BITS;
    localparam int BW = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;
    localparam int PW = AW + BW;
    // Rescaling of the L*R product to Q1.15.
    localparam int CSH = 2 * (SAMPLE_BITS - 1) - 15;
    localparam int SHR = (CSH > 0) ? CSH : 0;
    localparam int SHL = (CSH < 0) ? -CSH : 0;

    localparam logic signed [SW+1:0] LVL_MAX =
        ((SW+2)'(1) << (LEVEL_BITS - 1)) - (SW+2)'(1);
    localparam logic signed [SW+1:0] LVL_MIN = -LVL_MAX - (SW+2)'(1);
    localparam logic signed [15:0]   CORR_HI = 16'(CORR_MAX);
    localparam logic signed [15:0]   CORR_LO = -CORR_HI;

    // Sequencer and configuration.
    smb_state_t state_reg, state_next;
    logic [15:0]        level_coef_reg, level_coef_next;
    logic [15:0]        corr_coef_reg, corr_coef_next;
    logic [7:0]         hold_ticks_reg, hold_ticks_next;
    logic [12:0]        fall_step_reg, fall_step_next;
    logic signed [15:0] floor_db_reg, floor_db_next;

    // Ballistics state.
    logic signed [SW-1:0]  mid_sm_reg, mid_sm_next;
    logic signed [SW-1:0]  side_sm_reg, side_sm_next;
    logic signed [SW-1:0]  mid_pk_reg, mid_pk_next;
    logic signed [SW-1:0]  side_pk_reg, side_pk_next;
    logic [HOLD_BITS-1:0]  mid_hold_reg, mid_hold_next;
    logic [HOLD_BITS-1:0]  side_hold_reg, side_hold_next;
    logic signed [15:0]    corr_sm_reg, corr_sm_next;

    // Captured input word and intermediate results.
    logic signed [LEVEL_BITS-1:0]  mid_in_reg, mid_in_next;
    logic signed [LEVEL_BITS-1:0]  side_in_reg, side_in_next;
    logic signed [SAMPLE_BITS-1:0] left_reg, left_next;
    logic signed [SAMPLE_BITS-1:0] right_reg, right_next;
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic signed [15:0]            inst_reg, inst_next;

    // Output register.
    logic                         out_valid_reg, out_valid_next;
    logic signed [LEVEL_BITS-1:0] mid_level_reg, mid_level_next;
    logic signed [LEVEL_BITS-1:0] side_level_reg, side_level_next;
    logic signed [LEVEL_BITS-1:0] mid_pk_out_reg, mid_pk_out_next;
    logic signed [LEVEL_BITS-1:0] side_pk_out_reg, side_pk_out_next;
    logic signed [15:0]           corr_out_reg, corr_out_next;
    logic                         mid_silent_reg, mid_silent_next;
    logic                         side_silent_reg, side_silent_next;

    // Shared multiplier operands.
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;

    // Datapath helpers.
    logic signed [PW-1:0]   prod_shift;
    logic signed [SW+1:0]   lvl_sum;
    logic signed [SW-1:0]   lvl_cur;
    logic signed [SW-1:0]   lvl_sat;
    logic signed [SW-1:0]   pk_level;
    logic signed [SW-1:0]   pk_peak;
    logic [HOLD_BITS-1:0]   pk_count;
    logic signed [SW+1:0]   pk_fall;
    logic signed [SW+1:0]   pk_flr;
    logic signed [SW+1:0]   pk_pick;
    logic signed [SW-1:0]   pk_new;
    logic [HOLD_BITS-1:0]   pk_count_new;
    logic signed [PW-1:0]   lr_scaled;
    logic signed [15:0]     inst_clamp;
    logic signed [17:0]     corr_sum;
    logic signed [15:0]     corr_clamp;
    logic signed [SW:0]     silent_thr;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);

    assign out_valid     = out_valid_reg;
    assign mid_level     = mid_level_reg;
    assign side_level    = side_level_reg;
    assign mid_pk_level  = mid_pk_out_reg;
    assign side_pk_level = side_pk_out_reg;
    assign correlation   = corr_out_reg;
    assign mid_silent    = mid_silent_reg;
    assign side_silent   = side_silent_reg;

    // Operand selection for the shared multiplier: one product in each of ST_MID, ST_SIDE, ST_LR and ST_CMUL.
    always_comb
    begin
        case (state_reg)
            ST_MID:
            begin
                mul_a = AW'((SW+1)'(mid_in_reg) - (SW+1)'(mid_sm_reg));
                mul_b = BW'(signed'({1'b0, level_coef_reg}));
            end
            ST_SIDE:
            begin
                mul_a = AW'((SW+1)'(side_in_reg) - (SW+1)'(side_sm_reg));
                mul_b = BW'(signed'({1'b0, level_coef_reg}));
            end
            ST_LR:
            begin
                mul_a = AW'(left_reg);
                mul_b = BW'(right_reg);
            end
            ST_CMUL:
            begin
                mul_a = AW'(17'(inst_reg) - 17'(corr_sm_reg));
                mul_b = BW'(signed'({1'b0, corr_coef_reg}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next  = mul_a * mul_b;
    assign prod_shift = prod_reg >>> COEF_SHIFT;

    // Level update: the product of the previous state is added back to the
    // level it was taken from and saturated to the level port range.
    assign lvl_cur = (state_reg == ST_LR) ? side_sm_reg : mid_sm_reg;
    assign lvl_sum = (SW+2)'(lvl_cur) + signed'(prod_shift[SW+1:0]);
    assign lvl_sat = (lvl_sum > LVL_MAX) ? SW'(LVL_MAX) :
                     (lvl_sum < LVL_MIN) ? SW'(LVL_MIN) : SW'(lvl_sum);

    // Peak hold unit, shared: mid in ST_LR, side in ST_INST.
    assign pk_level = (state_reg == ST_INST) ? side_sm_reg   : mid_sm_reg;
    assign pk_peak  = (state_reg == ST_INST) ? side_pk_reg   : mid_pk_reg;
    assign pk_count = (state_reg == ST_INST) ? side_hold_reg : mid_hold_reg;
    assign pk_fall  = (SW+2)'(pk_peak) - (SW+2)'(signed'({1'b0, fall_step_reg}));
    assign pk_flr   = (SW+2)'(floor_db_reg);
    assign pk_pick  = (pk_fall > pk_flr) ? pk_fall : pk_flr;

    always_comb
    begin
        if (pk_level > pk_peak)
        begin
            pk_new       = pk_level;
            pk_count_new = HOLD_BITS'(hold_ticks_reg);
        end
        else if (pk_count != '0)
        begin
            pk_new       = pk_peak;
            pk_count_new = pk_count - HOLD_BITS'(1);
        end
        else
        begin
            pk_count_new = pk_count;
            if (pk_pick > LVL_MAX)
                pk_new = SW'(LVL_MAX);
            else if (pk_pick < LVL_MIN)
                pk_new = SW'(LVL_MIN);
            else
                pk_new = SW'(pk_pick);
        end
    end

    // Instantaneous correlation: L*R rescaled to Q1.15 and clamped.
    assign lr_scaled  = (prod_reg >>> SHR) <<< SHL;
    assign inst_clamp = (lr_scaled > PW'(CORR_HI)) ? CORR_HI :
                        (lr_scaled < PW'(CORR_LO)) ? CORR_LO : 16'(lr_scaled);

    // Smoothed correlation update.
    assign corr_sum   = 18'(corr_sm_reg) + signed'(prod_shift[17:0]);
    assign corr_clamp = (corr_sum > 18'(CORR_HI)) ? CORR_HI :
                        (corr_sum < 18'(CORR_LO)) ? CORR_LO : 16'(corr_sum);

    assign silent_thr = (SW+1)'(floor_db_reg) + (SW+1)'(ONE_DB);

    // Sequencer: next state and every register's next value.
    always_comb
    begin
        state_next       = state_reg;
        level_coef_next  = level_coef_reg;
        corr_coef_next   = corr_coef_reg;
        hold_ticks_next  = hold_ticks_reg;
        fall_step_next   = fall_step_reg;
        floor_db_next    = floor_db_reg;
        mid_sm_next      = mid_sm_reg;
        side_sm_next     = side_sm_reg;
        mid_pk_next      = mid_pk_reg;
        side_pk_next     = side_pk_reg;
        mid_hold_next    = mid_hold_reg;
        side_hold_next   = side_hold_reg;
        corr_sm_next     = corr_sm_reg;
        mid_in_next      = mid_in_reg;
        side_in_next     = side_in_reg;
        left_next        = left_reg;
        right_next       = right_reg;
        inst_next        = inst_reg;
        out_valid_next   = out_valid_reg;
        mid_level_next   = mid_level_reg;
        side_level_next  = side_level_reg;
        mid_pk_out_next  = mid_pk_out_reg;
        side_pk_out_next = side_pk_out_reg;
        corr_out_next    = corr_out_reg;
        mid_silent_next  = mid_silent_reg;
        side_silent_next = side_silent_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LEVEL_COEF: level_coef_next = cfg_data;
                CFG_CORR_COEF:  corr_coef_next  = cfg_data;
                CFG_HOLD_TICKS: hold_ticks_next = cfg_data[7:0];
                CFG_FALL_STEP:  fall_step_next  = cfg_data[12:0];
                CFG_FLOOR_DB:   floor_db_next   = signed'(cfg_data);
                default:        ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mid_in_next  = mid_db_in;
                    side_in_next = side_db_in;
                    left_next    = left_sample;
                    right_next   = right_sample;
                    state_next   = ST_MID;
                end
            end
            ST_MID:
                state_next = ST_SIDE;
            ST_SIDE:
            begin
                mid_sm_next = lvl_sat;
                state_next  = ST_LR;
            end
            ST_LR:
            begin
                side_sm_next  = lvl_sat;
                mid_pk_next   = pk_new;
                mid_hold_next = pk_count_new;
                state_next    = ST_INST;
            end
            ST_INST:
            begin
                inst_next      = inst_clamp;
                side_pk_next   = pk_new;
                side_hold_next = pk_count_new;
                state_next     = ST_CMUL;
            end
            ST_CMUL:
                state_next = ST_CUPD;
            ST_CUPD:
            begin
                corr_sm_next = corr_clamp;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Wait here while the previous word is still unread.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    mid_level_next   = mid_sm_reg[LEVEL_BITS-1:0];
                    side_level_next  = side_sm_reg[LEVEL_BITS-1:0];
                    mid_pk_out_next  = mid_pk_reg[LEVEL_BITS-1:0];
                    side_pk_out_next = side_pk_reg[LEVEL_BITS-1:0];
                    corr_out_next    = corr_sm_reg;
                    mid_silent_next  = ((SW+1)'(mid_sm_reg) < silent_thr);
                    side_silent_next = ((SW+1)'(side_sm_reg) < silent_thr);
                    state_next       = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control and ballistics state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            level_coef_reg <= LEVEL_COEF_RST;
            corr_coef_reg  <= CORR_COEF_RST;
            hold_ticks_reg <= HOLD_TICKS_RST;
            fall_step_reg  <= FALL_STEP_RST;
            floor_db_reg   <= FLOOR_DB_RST;
            mid_sm_reg     <= SW'(RESET_DB);
            side_sm_reg    <= SW'(RESET_DB);
            mid_pk_reg     <= SW'(RESET_DB);
            side_pk_reg    <= SW'(RESET_DB);
            mid_hold_reg   <= '0;
            side_hold_reg  <= '0;
            corr_sm_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            level_coef_reg <= level_coef_next;
            corr_coef_reg  <= corr_coef_next;
            hold_ticks_reg <= hold_ticks_next;
            fall_step_reg  <= fall_step_next;
            floor_db_reg   <= floor_db_next;
            mid_sm_reg     <= mid_sm_next;
            side_sm_reg    <= side_sm_next;
            mid_pk_reg     <= mid_pk_next;
            side_pk_reg    <= side_pk_next;
            mid_hold_reg   <= mid_hold_next;
            side_hold_reg  <= side_hold_next;
            corr_sm_reg    <= corr_sm_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        mid_in_reg      <= mid_in_next;
        side_in_reg     <= side_in_next;
        left_reg        <= left_next;
        right_reg       <= right_next;
        prod_reg        <= prod_next;
        inst_reg        <= inst_next;
        mid_level_reg   <= mid_level_next;
        side_level_reg  <= side_level_next;
        mid_pk_out_reg  <= mid_pk_out_next;
        side_pk_out_reg <= side_pk_out_next;
        corr_out_reg    <= corr_out_next;
        mid_silent_reg  <= mid_silent_next;
        side_silent_reg <= side_silent_next;
    end

    // An accepted word always starts the mid level product next.
    `SMB_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state_reg == ST_MID)
    // A finished word never overwrites an unread one.
    `SMB_ASSERT_NXT(a_emit_waits, state_reg == ST_EMIT && out_valid_reg && !out_ready,
                    state_reg == ST_EMIT && $stable(mid_level_reg))
    // The smoothed correlation never reaches minus full scale.
    `SMB_ASSERT_IMP(a_corr_range, state_reg == ST_EMIT, corr_sm_reg >= CORR_LO)

endmodule

`default_nettype wire

FILE: sim/stereo_meter_ballistics_top_tb.sv
// Self-checking testbench for stereo_meter_ballistics_top. It drives metering words and
// register writes with random idling on both sides, and checks every output word field by field.
// Depends on smb_pkg and the block's RTL; it reads and writes no files.
`timescale 1ns / 1ps

module stereo_meter_ballistics_top_tb;

    import smb_pkg::*;

    localparam longint LEVEL_MAX   = (longint'(1) << (LEVEL_BITS_DEF - 1)) - 1;
    localparam int     PROD_SHIFT  = 2 * (SAMPLE_BITS_DEF - 1) - 15;
    localparam int     CYCLE_LIMIT = 300000;
    localparam int     DRAIN_SLACK = 24;
    localparam int     REPORT_MAX  = 10;

    // Register indexes that the block does not decode. Writes to them must change nothing.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LAST  = 3'd7;

    localparam logic signed [15:0] FS_POS = 16'sh7FFF;
    localparam logic signed [15:0] FS_NEG = 16'sh8000;

    typedef enum int {
        SCENE_PROGRAMME,
        SCENE_QUIET,
        SCENE_NOISE
    } scene_t;

    // One output word as the block presents it.
    typedef struct packed {
        logic signed [15:0] mid_level;
        logic signed [15:0] side_level;
        logic signed [15:0] mid_pk_level;
        logic signed [15:0] side_pk_level;
        logic signed [15:0] correlation;
        logic               mid_silent;
        logic               side_silent;
    } meter_word_t;

    // The scoreboard keeps its own copy of the meter state and registers. Each accepted
    // input word advances that state and queues the output word it must produce; each
    // output word from the block is compared with the oldest one queued.
    class meter_scoreboard;
        logic [15:0]        level_coef;
        logic [15:0]        corr_coef;
        logic [7:0]         hold_ticks;
        logic [12:0]        fall_step;
        logic signed [15:0] floor_db;
        longint             mid_lvl;
        longint             side_lvl;
        longint             mid_pk;
        longint             side_pk;
        longint             corr_avg;
        int unsigned        mid_hold;
        int unsigned        side_hold;
        meter_word_t        owed_words[$];
        int                 mismatches;
        int                 words_checked;

        function new();
            level_coef    = LEVEL_COEF_RST;
            corr_coef     = CORR_COEF_RST;
            hold_ticks    = HOLD_TICKS_RST;
            fall_step     = FALL_STEP_RST;
            floor_db      = FLOOR_DB_RST;
            mid_lvl       = RESET_DB;
            side_lvl      = RESET_DB;
            mid_pk        = RESET_DB;
            side_pk       = RESET_DB;
            corr_avg      = 0;
            mid_hold      = 0;
            side_hold     = 0;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] data);
            case (idx)
                CFG_LEVEL_COEF: level_coef = data;
                CFG_CORR_COEF:  corr_coef  = data;
                CFG_HOLD_TICKS: hold_ticks = data[7:0];
                CFG_FALL_STEP:  fall_step  = data[12:0];
                CFG_FLOOR_DB:   floor_db   = data;
                default: ;
            endcase
        endfunction

        function longint clamp(input longint v, input longint lo, input longint hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        // One-pole step; the arithmetic shift rounds towards minus infinity.
        function longint one_pole(input longint cur, input longint target, input longint coef);
            return cur + (((target - cur) * coef) >>> COEF_SHIFT);
        endfunction

        function void advance_peak(input longint lvl, inout longint pk, inout int unsigned cnt);
            longint dropped;
            if (lvl > pk) begin
                pk  = lvl;
                cnt = hold_ticks;
            end
            else if (cnt > 0) begin
                cnt = cnt - 1;
            end
            else begin
                dropped = pk - longint'(fall_step);
                if (dropped < longint'(floor_db))
                    dropped = longint'(floor_db);
                pk = clamp(dropped, -LEVEL_MAX - 1, LEVEL_MAX);
            end
        endfunction

        function void note_packet(input logic signed [15:0] mid, input logic signed [15:0] side,
                                  input logic signed [15:0] lft, input logic signed [15:0] rgt);
            meter_word_t w;
            longint      inst;
            mid_lvl  = clamp(one_pole(mid_lvl, longint'(mid), longint'(level_coef)),
                             -LEVEL_MAX - 1, LEVEL_MAX);
            side_lvl = clamp(one_pole(side_lvl, longint'(side), longint'(level_coef)),
                             -LEVEL_MAX - 1, LEVEL_MAX);
            advance_peak(mid_lvl, mid_pk, mid_hold);
            advance_peak(side_lvl, side_pk, side_hold);
            inst     = clamp((longint'(lft) * longint'(rgt)) >>> PROD_SHIFT, -CORR_MAX, CORR_MAX);
            corr_avg = clamp(one_pole(corr_avg, inst, longint'(corr_coef)), -CORR_MAX, CORR_MAX);
            w.mid_level     = mid_lvl[15:0];
            w.side_level    = side_lvl[15:0];
            w.mid_pk_level  = mid_pk[15:0];
            w.side_pk_level = side_pk[15:0];
            w.correlation   = corr_avg[15:0];
            w.mid_silent    = (mid_lvl < longint'(floor_db) + ONE_DB);
            w.side_silent   = (side_lvl < longint'(floor_db) + ONE_DB);
            owed_words.push_back(w);
        endfunction

        function void compare_field(input string name, input logic signed [31:0] want,
                                    input logic signed [31:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: %s mismatch on word %0d: expected %0d, got %0d",
                             $time, name, words_checked, want, got);
            end
        endfunction

        function void check_word(input meter_word_t got);
            meter_word_t want;
            if (owed_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: output word with no prediction waiting", $time);
                return;
            end
            want = owed_words.pop_front();
            compare_field("mid_level", want.mid_level, got.mid_level);
            compare_field("side_level", want.side_level, got.side_level);
            compare_field("mid_pk_level", want.mid_pk_level, got.mid_pk_level);
            compare_field("side_pk_level", want.side_pk_level, got.side_pk_level);
            compare_field("correlation", want.correlation, got.correlation);
            compare_field("mid_silent", want.mid_silent, got.mid_silent);
            compare_field("side_silent", want.side_silent, got.side_silent);
            words_checked++;
        endfunction
    endclass

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data      = '0;
    logic                        in_valid      = 1'b0;
    logic                        in_ready;
    logic signed [15:0]          mid_db_in     = '0;
    logic signed [15:0]          side_db_in    = '0;
    logic signed [15:0]          left_sample   = '0;
    logic signed [15:0]          right_sample  = '0;
    logic                        out_valid;
    logic                        out_ready     = 1'b0;
    logic signed [15:0]          mid_level;
    logic signed [15:0]          side_level;
    logic signed [15:0]          mid_pk_level;
    logic signed [15:0]          side_pk_level;
    logic signed [15:0]          correlation;
    logic                        mid_silent;
    logic                        side_silent;

    meter_scoreboard             sb;
    logic [CFG_INDEX_BITS-1:0]   cfg_idx_q[$];
    logic [15:0]                 cfg_dat_q[$];
    int                          cycle_count     = 0;
    int                          words_sent      = 0;
    int                          settings_used   = 1;
    int                          send_calm_left  = 0;
    int                          sink_calm_left  = 0;
    int                          sink_stall_left = 0;
    scene_t                      scene           = SCENE_PROGRAMME;
    int                          scene_left      = 0;

    stereo_meter_ballistics_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mid_db_in     (mid_db_in),
        .side_db_in    (side_db_in),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mid_level     (mid_level),
        .side_level    (side_level),
        .mid_pk_level  (mid_pk_level),
        .side_pk_level (side_pk_level),
        .correlation   (correlation),
        .mid_silent    (mid_silent),
        .side_silent   (side_silent)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle lengths: mostly drawn from a short range, now and then a long gap.
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // The sender goes back to back for about half of its words and, for the occasional
    // calm stretch, for every word, so that the block also sees its full input rate.
    function automatic int sender_gap();
        if (send_calm_left > 0) begin
            send_calm_left--;
            return 0;
        end
        if ($urandom_range(0, 99) < 4) begin
            send_calm_left = $urandom_range(30, 120);
            return 0;
        end
        if ($urandom_range(0, 1) == 0)
            return 0;
        return idle_length();
    endfunction

    // Offers one word and returns at the edge where it is taken. Valid is lowered only when a
    // gap follows, so a back-to-back word never sees valid dropped and raised in one step.
    task automatic send_packet(input logic signed [15:0] mid, input logic signed [15:0] side,
                               input logic signed [15:0] lft, input logic signed [15:0] rgt);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        mid_db_in    <= mid;
        side_db_in   <= side;
        left_sample  <= lft;
        right_sample <= rgt;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_packet(mid, side, lft, rgt);
        words_sent++;
    endtask

    // Holds the sender back until every word in flight has come out of the block.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.owed_words.size() != 0)
            @(posedge clk);
    endtask

    // Writes the queued registers back to back; the scoreboard takes each value at the
    // edge where the block accepts it.
    task automatic commit_regs();
        cfg_valid <= 1'b1;
        cfg_index <= cfg_idx_q[0];
        cfg_data  <= cfg_dat_q[0];
        while (cfg_idx_q.size() > 0) begin
            @(posedge clk);
            if (cfg_ready === 1'b1) begin
                sb.apply_reg(cfg_idx_q.pop_front(), cfg_dat_q.pop_front());
                if (cfg_idx_q.size() > 0) begin
                    cfg_index <= cfg_idx_q[0];
                    cfg_data  <= cfg_dat_q[0];
                end
            end
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // A new setting is only written once the block has drained. With a spare write, a random
    // word also goes to an undecoded index in the middle of the sequence.
    task automatic set_regs(input logic [15:0] lvl_coef, input logic [15:0] cor_coef,
                            input logic [15:0] hold, input logic [15:0] fall,
                            input logic [15:0] flr, input bit with_spare);
        wait_drained();
        cfg_idx_q.push_back(CFG_LEVEL_COEF);
        cfg_dat_q.push_back(lvl_coef);
        cfg_idx_q.push_back(CFG_CORR_COEF);
        cfg_dat_q.push_back(cor_coef);
        if (with_spare) begin
            cfg_idx_q.push_back(CFG_INDEX_BITS'($urandom_range(CFG_SPARE_FIRST,
                                                                CFG_SPARE_LAST)));
            cfg_dat_q.push_back(16'($urandom));
        end
        cfg_idx_q.push_back(CFG_HOLD_TICKS);
        cfg_dat_q.push_back(hold);
        cfg_idx_q.push_back(CFG_FALL_STEP);
        cfg_dat_q.push_back(fall);
        cfg_idx_q.push_back(CFG_FLOOR_DB);
        cfg_dat_q.push_back(flr);
        commit_regs();
    endtask

    // Random words come in scenes. Programme material keeps the levels in the usual metering
    // range and pairs the samples in phase, in anti-phase, at full scale or independently.
    // Quiet runs drive both levels to minus 60 dB or below, so that the hold can run out and the peaks fall.
    // Noise scenes toggle every bit of every field.
    task automatic run_random(input int count, input int pause_at);
        logic signed [15:0] mid;
        logic signed [15:0] side;
        logic signed [15:0] lft;
        logic signed [15:0] rgt;
        int                 roll;
        for (int k = 0; k < count; k++) begin
            if (k == pause_at)
                wait_drained();
            if (scene_left == 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 50) begin
                    scene      = SCENE_PROGRAMME;
                    scene_left = $urandom_range(5, 40);
                end
                else if (roll < 80) begin
                    scene      = SCENE_QUIET;
                    scene_left = $urandom_range(20, 70);
                end
                else begin
                    scene      = SCENE_NOISE;
                    scene_left = $urandom_range(3, 15);
                end
            end
            scene_left--;
            case (scene)
                SCENE_PROGRAMME: begin
                    mid  = 16'(-int'($urandom_range(0, 15360)));
                    side = 16'(int'(mid) - int'($urandom_range(0, 3072)));
                    lft  = 16'($urandom);
                    case ($urandom_range(0, 3))
                        0: rgt = 16'($urandom);
                        1: rgt = lft;
                        2: rgt = ~lft;
                        default: begin
                            lft = $urandom_range(0, 1) ? FS_POS : FS_NEG;
                            rgt = $urandom_range(0, 1) ? FS_POS : FS_NEG;
                        end
                    endcase
                end
                SCENE_QUIET: begin
                    mid  = 16'(-int'($urandom_range(15360, 32768)));
                    side = 16'(-int'($urandom_range(15360, 32768)));
                    lft  = 16'(int'($urandom_range(0, 64)) - 32);
                    rgt  = 16'(int'($urandom_range(0, 64)) - 32);
                end
                default: begin
                    mid  = 16'($urandom);
                    side = 16'($urandom);
                    lft  = 16'($urandom);
                    rgt  = 16'($urandom);
                end
            endcase
            send_packet(mid, side, lft, rgt);
        end
    endtask

    // Output side: every accepted word is checked, then ready is chosen for the next cycle.
    // Short stalls are common, long ones rare, and calm stretches keep ready high throughout.
    always @(posedge clk)
    begin : result_sink
        meter_word_t got;
        int          roll;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            got.mid_level     = mid_level;
            got.side_level    = side_level;
            got.mid_pk_level  = mid_pk_level;
            got.side_pk_level = side_pk_level;
            got.correlation   = correlation;
            got.mid_silent    = mid_silent;
            got.side_silent   = side_silent;
            sb.check_word(got);
        end
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else if (sink_calm_left > 0) begin
            sink_calm_left--;
            out_ready <= 1'b1;
        end
        else if (sink_stall_left > 0) begin
            sink_stall_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                sink_calm_left = $urandom_range(50, 200);
            else if (roll < 30)
                sink_stall_left = idle_length();
        end
    end

    // A hung handshake must not leave the run spinning for ever.
    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d words still owed",
                     cycle_count, sb.owed_words.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset settings: full-scale levels both ways, the product of
        // two negative full-scale samples that must clamp to just below one, the other sign
        // combinations, alternating bit patterns and levels driven far below the floor.
        send_packet(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_packet(FS_POS, FS_NEG, FS_NEG, FS_NEG);
        send_packet(FS_NEG, FS_POS, FS_POS, FS_NEG);
        send_packet(FS_POS, FS_NEG, FS_NEG, FS_POS);
        send_packet(FS_POS, FS_POS, FS_POS, FS_POS);
        send_packet(16'sd0, -16'sd3072, 16'sh4000, 16'shC000);
        repeat (4)
            send_packet(FS_NEG, FS_NEG, 16'sd0, 16'sd0);
        send_packet(-16'sd15360, -16'sd15104, 16'sd1, -16'sd1);
        send_packet(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
        send_packet(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
        send_packet(FS_NEG, FS_NEG, FS_NEG, FS_POS);

        // Fastest settings: near-tracking filters, no hold, a 30 dB fall and the lowest
        // floor. A new peak starts to fall on the very next word, down to the bottom of range.
        set_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd7680, 16'h8000, 1'b0);
        send_packet(FS_POS, FS_POS, FS_NEG, FS_NEG);
        send_packet(FS_POS, 16'sd0, FS_POS, FS_NEG);
        repeat (6)
            send_packet(FS_NEG, FS_NEG, 16'sd0, 16'sd0);
        run_random(90, -1);

        // Frozen filters, the longest hold, no fall and the floor at 0 dB: the first fall
        // finds the peaks below the new floor and lifts them to it.
        set_regs(16'h0000, 16'h0000, 16'd255, 16'd0, 16'h0000, 1'b0);
        run_random(60, -1);

        set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(0, 60)),
                 16'($urandom_range(0, 7680)), 16'(-int'($urandom_range(0, 32768))), 1'b1);
        run_random(100, -1);

        // Short hold so that peaks fall often; halfway through, the sender waits for the
        // block to empty completely before carrying on.
        set_regs(16'd16384, 16'd9830, 16'd3, 16'd230, 16'(-16'sd15360), 1'b0);
        run_random(110, 55);

        set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(0, 60)),
                 16'($urandom_range(0, 7680)), 16'(-int'($urandom_range(0, 32768))), 1'b1);
        run_random(100, -1);

        set_regs(LEVEL_COEF_RST, CORR_COEF_RST, 16'(HOLD_TICKS_RST), 16'(FALL_STEP_RST),
                 FLOOR_DB_RST, 1'b0);
        run_random(90, -1);

        // Let the last words out, then give a stray extra word time to show up.
        wait_drained();
        repeat (DRAIN_SLACK) @(posedge clk);

        $display("Covered %0d metering words over %0d register settings, each register at both",
                 words_sent, settings_used);
        $display("ends of its range; %0d output words compared, %0d field mismatches.",
                 sb.words_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.owed_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
